@@ sv/set_assoc_lru_cache_sim_assert.svh @@
// assertion macros for the cache tag store block
// expects clk and rst_n in the scope of each use
`ifndef SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("set_assoc_lru_cache_sim: assertion failed");

// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set_assoc_lru_cache_sim: assertion failed");

`endif

@@ sv/sacl_pkg.sv @@
// shared types and constants of the set-associative cache tag store
// no dependencies
package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_BITS        = 64;
  localparam logic [63:0] ADDR_MASK = ~64'd0 >> (64 - ADDR_BITS);

  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [1:0] OP_FETCH  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] address;
  } in_t;

  typedef struct packed {
    logic             was_hit;
    logic             was_miss;
    logic             was_evict;
    logic             last_of_item;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } out_t;

endpackage

@@ sv/set_assoc_lru_cache_sim.sv @@
// top level of the set-associative cache tag store with true lru and totals
// depends on sacl_pkg, sacl_touch and set_assoc_lru_cache_sim_assert.svh
//
// usage:
//   in channel (in_valid/in_stall/in_data) carries one access per beat:
//   operation and byte address. out channel (out_valid/out_stall/out_data)
//   carries one beat per lookup: hit/miss/evict flags, last_of_item and the
//   running totals. fetches give no beat, load and store give one, modify
//   gives two (first with last_of_item low).
//   cfg_we/cfg_index/cfg_data write set_bits, ways and block_bits; write
//   only while the block is idle.
//   timing: in_stall is low only in the idle state. after acceptance one
//   lookup runs decode, tag compares and update; the compares step through
//   the ways in order up to the hit, or through all ways in use on a miss;
//   the single tag comparator checks one way per cycle out of the tag ram.
//   a modify runs two lookups back to back. the update step writes the
//   result into an output register; each access ends in the idle state.
//   a stalled receiver holds the update step until the output register
//   frees up; the next access is still taken while a result waits.
//   reset: totals clear, config returns to 4/1/4, all lines read invalid
//   through per-set flags, so no clearing pass is needed.
`include "set_assoc_lru_cache_sim_assert.svh"

module set_assoc_lru_cache_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SB_W      = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W      = $clog2(MAX_WAYS + 1);
  localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
  localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef logic [MAX_WAYS-1:0][WAY_W-1:0] rank_row_t;

  state_t             state_r;
  logic [1:0]         op_r;
  logic [63:0]        addr_r;
  logic               second_r;
  logic [SET_W-1:0]   idx_r;
  logic [63:0]        tag_r;
  logic [WAY_W-1:0]   w_r;
  logic               hit_r;
  logic [WAY_W-1:0]   hit_way_r;
  logic               inv_found_r;
  logic [WAY_W-1:0]   inv_way_r;
  logic [WAY_W-1:0]   vict_way_r;
  logic [WAY_W-1:0]   vict_rank_r;
  logic               row_ok_r;
  logic               out_valid_r;
  out_t               out_data_r;
  logic [CNT_W-1:0]   hit_cnt_r;
  logic [CNT_W-1:0]   miss_cnt_r;
  logic [CNT_W-1:0]   evict_cnt_r;
  logic [2:0]         set_bits_r;
  logic [3:0]         ways_r;
  logic [5:0]         block_bits_r;
  logic [NUM_SETS-1:0] row_init_r;

  logic [63:0]         tag_mem [NUM_LINES];
  logic [MAX_WAYS-1:0] val_mem [NUM_SETS];
  rank_row_t           rank_mem [NUM_SETS];
  logic [63:0]         tag_q;
  logic [MAX_WAYS-1:0] val_q;
  rank_row_t           rank_q;

  logic [SB_W-1:0]     s_eff;
  logic [NW_W-1:0]     nw_eff;
  logic [6:0]          tag_sh;
  logic [63:0]         blk;
  logic [SET_W-1:0]    set_mask;
  logic [SET_W-1:0]    idx_calc;
  logic [63:0]         tag_calc;
  logic [MAX_WAYS-1:0] row_valid;
  rank_row_t           row_rank;
  logic                cur_valid;
  logic [WAY_W-1:0]    cur_rank;
  logic                tag_match;
  logic                last_way;
  logic [WAY_W-1:0]    pos;
  logic                use_all;
  logic                evict;
  logic                can_emit;
  logic                upd_go;
  logic                tag_rd;
  logic [LINE_W-1:0]   tag_rd_line;
  logic [MAX_WAYS-1:0] new_valid;
  rank_row_t           new_rank;
  logic [CNT_W-1:0]    hit_cnt_nxt;
  logic [CNT_W-1:0]    miss_cnt_nxt;
  logic [CNT_W-1:0]    evict_cnt_nxt;

  function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                 input logic [WAY_W-1:0] w);
    return LINE_W'(s) * LINE_W'(MAX_WAYS) + LINE_W'(w);
  endfunction

  // effective configuration
  assign s_eff  = ({29'd0, set_bits_r} > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
                                                        : SB_W'(set_bits_r);
  assign nw_eff = (ways_r == 4'd0) ? NW_W'(1) :
                  ({28'd0, ways_r} > MAX_WAYS) ? NW_W'(MAX_WAYS) : NW_W'(ways_r);

  // address split
  assign blk      = addr_r >> block_bits_r;
  assign set_mask = ~({SET_W{1'b1}} << s_eff);
  assign idx_calc = blk[SET_W-1:0] & set_mask;
  assign tag_sh   = 7'(block_bits_r) + 7'(s_eff);
  assign tag_calc = (tag_sh >= 7'd64) ? 64'd0 : (addr_r >> tag_sh);

  // row contents, unwritten sets read as all zero
  assign row_valid = row_ok_r ? val_q : '0;
  assign row_rank  = row_ok_r ? rank_q : '0;
  assign cur_valid = row_valid[w_r];
  assign cur_rank  = row_rank[w_r];
  assign tag_match = cur_valid && (tag_q == tag_r);
  assign last_way  = (NW_W'(w_r) == nw_eff - NW_W'(1));

  assign pos      = hit_r ? hit_way_r : (inv_found_r ? inv_way_r : vict_way_r);
  assign use_all  = !hit_r && inv_found_r;
  assign evict    = !hit_r && !inv_found_r;
  assign can_emit = !out_valid_r || !out_stall;
  assign upd_go   = (state_r == ST_UPDATE) && can_emit;

  assign hit_cnt_nxt   = hit_cnt_r + CNT_W'(hit_r);
  assign miss_cnt_nxt  = miss_cnt_r + CNT_W'(!hit_r);
  assign evict_cnt_nxt = evict_cnt_r + CNT_W'(evict);

  assign tag_rd      = (state_r == ST_DECODE) ||
                       ((state_r == ST_SCAN) && !last_way && !tag_match);
  assign tag_rd_line = (state_r == ST_DECODE) ? line_of(idx_calc, '0)
                                              : line_of(idx_r, w_r + WAY_W'(1));

  sacl_touch #(
    .MAX_WAYS (MAX_WAYS)
  ) u_touch (
    .row_valid (row_valid),
    .row_rank  (row_rank),
    .nw        (nw_eff),
    .pos       (pos),
    .use_all   (use_all),
    .new_valid (new_valid),
    .new_rank  (new_rank)
  );

  // tag ram: one compare read per cycle
  always_ff @(posedge clk) begin
    if (upd_go && !hit_r) begin
      tag_mem[line_of(idx_r, pos)] <= tag_r;
    end
    if (tag_rd) begin
      tag_q <= tag_mem[tag_rd_line];
    end
  end

  // per-set valid and rank row
  always_ff @(posedge clk) begin
    if (upd_go) begin
      val_mem[idx_r]  <= new_valid;
      rank_mem[idx_r] <= new_rank;
    end
    if (state_r == ST_DECODE) begin
      val_q  <= val_mem[idx_calc];
      rank_q <= rank_mem[idx_calc];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      second_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      set_bits_r   <= SET_BITS_RST;
      ways_r       <= WAYS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      row_init_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_bits_r   <= cfg_data[2:0];
          CFG_WAYS:       ways_r       <= cfg_data[3:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && !upd_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r     <= in_data.operation;
            addr_r   <= in_data.address & ADDR_MASK;
            second_r <= 1'b0;
            case (in_data.operation) inside
              OP_LOAD, OP_STORE, OP_MODIFY: state_r <= ST_DECODE;
              default:                      state_r <= ST_IDLE;
            endcase
          end
        end
        ST_DECODE: begin
          idx_r       <= idx_calc;
          tag_r       <= tag_calc;
          row_ok_r    <= row_init_r[idx_calc];
          w_r         <= '0;
          hit_r       <= 1'b0;
          inv_found_r <= 1'b0;
          vict_way_r  <= '0;
          vict_rank_r <= '0;
          state_r     <= ST_SCAN;
        end
        ST_SCAN: begin
          if (tag_match) begin
            hit_r     <= 1'b1;
            hit_way_r <= w_r;
            state_r   <= ST_UPDATE;
          end else begin
            if (!cur_valid && !inv_found_r) begin
              inv_found_r <= 1'b1;
              inv_way_r   <= w_r;
            end
            if ((w_r == '0) || (cur_rank > vict_rank_r)) begin
              vict_way_r  <= w_r;
              vict_rank_r <= cur_rank;
            end
            if (last_way) begin
              state_r <= ST_UPDATE;
            end else begin
              w_r <= w_r + WAY_W'(1);
            end
          end
        end
        ST_UPDATE: begin
          if (can_emit) begin
            hit_cnt_r                <= hit_cnt_nxt;
            miss_cnt_r               <= miss_cnt_nxt;
            evict_cnt_r              <= evict_cnt_nxt;
            row_init_r[idx_r]        <= 1'b1;
            out_valid_r              <= 1'b1;
            out_data_r.was_hit       <= hit_r;
            out_data_r.was_miss      <= !hit_r;
            out_data_r.was_evict     <= evict;
            out_data_r.last_of_item  <= !((op_r == OP_MODIFY) && !second_r);
            out_data_r.hit_total     <= hit_cnt_nxt;
            out_data_r.miss_total    <= miss_cnt_nxt;
            out_data_r.evict_total   <= evict_cnt_nxt;
            if ((op_r == OP_MODIFY) && !second_r) begin
              second_r <= 1'b1;
              state_r  <= ST_DECODE;
            end else begin
              state_r  <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SACL_ASSERT_IMPL(a_one_outcome, out_valid_r, out_data_r.was_hit ^ out_data_r.was_miss)
  `SACL_ASSERT_IMPL(a_evict_on_miss, out_valid_r && out_data_r.was_evict, out_data_r.was_miss)
  `SACL_ASSERT_IMPL(a_second_hits, upd_go && second_r, hit_r)
  `SACL_ASSERT_IMPL(a_scan_in_range, state_r == ST_SCAN, NW_W'(w_r) < nw_eff)
  `SACL_ASSERT_NEXT(a_emit_beat, upd_go, out_valid_r && (out_data_r.miss_total == miss_cnt_r))

endmodule

@@ sv/sacl_touch.sv @@
// lru rank update of one set row: brings one way to the front
// depends on sacl_pkg
module sacl_touch
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic [MAX_WAYS-1:0]                                    row_valid,
  input  logic [MAX_WAYS-1:0][((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] row_rank,
  input  logic [$clog2(MAX_WAYS+1)-1:0]                          nw,
  input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0]     pos,
  input  logic                                                   use_all,
  output logic [MAX_WAYS-1:0]                                    new_valid,
  output logic [MAX_WAYS-1:0][((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] new_rank
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W   = $clog2(MAX_WAYS + 1);
  localparam logic [WAY_W-1:0] RANK_MAX = WAY_W'(MAX_WAYS - 1);

  always_comb begin
    logic [WAY_W-1:0] limit;
    logic             bump;
    limit = row_rank[pos];
    bump  = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      bump = (NW_W'(w) < nw) && (WAY_W'(w) != pos) && row_valid[w] &&
             (use_all || (row_rank[w] < limit)) && (row_rank[w] < RANK_MAX);
      new_rank[w] = bump ? row_rank[w] + WAY_W'(1) : row_rank[w];
    end
    new_rank[pos] = '0;
    new_valid      = row_valid;
    new_valid[pos] = 1'b1;
  end

endmodule
